// ===== sv/snfc_pkg.sv =====
package snfc_pkg;

  localparam int PAGE_BYTES_DEF = 256;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_READ  = 3'd1,
    OP_PROG  = 3'd2,
    OP_SECT  = 3'd3,
    OP_CHIP  = 3'd4,
    OP_WAKE  = 3'd5,
    OP_SLEEP = 3'd6,
    OP_DATA  = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    SEG_A    = 2'd0,
    SEG_B    = 2'd1,
    SEG_POLL = 2'd2
  } segment_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_BUSY    = 2'd1,
    ERR_ALIGN   = 2'd2,
    ERR_PARTIAL = 2'd3
  } error_t;

  localparam logic [7:0] CMD_PROG   = 8'h02;
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_STATUS = 8'h05;
  localparam logic [7:0] CMD_SECT   = 8'h20;
  localparam logic [7:0] CMD_CHIP   = 8'hC7;
  localparam logic [7:0] CMD_WAKE   = 8'hAB;
  localparam logic [7:0] CMD_SLEEP  = 8'hB9;

  localparam logic REG_QUARTER = 1'b0;
  localparam logic REG_SETTLE  = 1'b1;

endpackage

// ===== sv/spi_nor_flash_command_sequencer.sv =====
// channel | dir | tdata fields (low bit up)                         | tuser
// s_axis  | in  | opcode 3, address 24, data_byte 8, length 16,     | -
//         |     | miso_bit                                          |
// m_axis  | out | sck, mosi, chip_select_n, read_valid, read_byte 8, | -
//         |     | read_last, busy_res, done_res, error 2           |
// one item per cycle while the output register is not stalled; each item gives one registered result item.
// the sequencer advances one step per tick item; the page buffer is a
// memory with a registered read, addressed by the next byte index so the
// page byte is ready as soon as the byte counter holds the new index.
// rst is synchronous; the page buffer is not cleared (fill count guards it).
// s_axis_tready is low in reset and while the output register is full and not taken.
module spi_nor_flash_command_sequencer #(
  parameter int PAGE_BYTES = snfc_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], address[26:3], data_byte[34:27], length[50:35], miso_bit[51]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sck[0], mosi[1], chip_select_n[2], read_valid[3], read_byte[11:4],
  // read_last[12], busy_res[13], done_res[14], error[16:15]
  output logic [23:0] m_axis_tdata
);
  import snfc_pkg::*;

  localparam int PW = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    PH_IDLE, PH_CS_ON, PH_B0, PH_B1, PH_B2, PH_B3, PH_CS_OFF, PH_FINISH
  } phase_t;

  // config
  logic [7:0]  quarter_bit_ticks;
  logic [15:0] cs_settle_ticks;

  // state
  phase_t      phase_state;
  logic [15:0] wait_counter;
  logic [2:0]  bit_counter;
  logic [7:0]  transmit_shift, receive_shift;
  logic [16:0] byte_counter;
  logic [23:0] command_address;
  opcode_t     active_command;
  logic [PW:0] page_fill;
  logic        status_busy_seen;
  segment_t    segment;
  logic [15:0] read_length;
  logic        pin_sck, pin_mosi, pin_csn;

  logic [7:0]  page_buffer [PAGE_BYTES];
  logic [7:0]  page_rd;

  opcode_t     op;
  logic [23:0] in_addr;
  logic [7:0]  in_data;
  logic [15:0] in_len;
  logic        in_miso;
  logic        accept;

  assign op      = opcode_t'(s_axis_tdata[2:0]);
  assign in_addr = s_axis_tdata[26:3];
  assign in_data = s_axis_tdata[34:27];
  assign in_len  = s_axis_tdata[50:35];
  assign in_miso = s_axis_tdata[51];
  assign s_axis_tready = !rst && (!m_axis_tvalid || m_axis_tready);
  assign accept  = s_axis_tvalid && s_axis_tready;

  // segment length
  logic [16:0] seg_len;
  always_comb begin
    if (segment == SEG_POLL) seg_len = 17'd2;
    else begin
      case (active_command)
        OP_READ: seg_len = 17'd4 + {1'b0, read_length};
        OP_PROG: seg_len = (segment == SEG_A) ? 17'd1 : 17'(4 + PAGE_BYTES);
        OP_SECT: seg_len = 17'd4;
        default: seg_len = 17'd1;
      endcase
    end
  end

  logic [7:0] addr_byte;
  always_comb begin
    if (byte_counter[1:0] == 2'd1)      addr_byte = command_address[23:16];
    else if (byte_counter[1:0] == 2'd2) addr_byte = command_address[15:8];
    else                                addr_byte = command_address[7:0];
  end

  // byte to send at the current byte index
  logic [7:0] byte_out;
  always_comb begin
    if (segment == SEG_POLL) byte_out = (byte_counter == 17'd0) ? CMD_STATUS : 8'h00;
    else begin
      case (active_command)
        OP_READ: byte_out = (byte_counter == 17'd0) ? CMD_READ :
                            (byte_counter < 17'd4) ? addr_byte : 8'h00;
        OP_PROG: byte_out = (segment == SEG_A) ? CMD_WREN :
                            (byte_counter == 17'd0) ? CMD_PROG :
                            (byte_counter < 17'd4) ? addr_byte : page_rd;
        OP_SECT: byte_out = (byte_counter == 17'd0) ? CMD_SECT : addr_byte;
        OP_CHIP: byte_out = CMD_CHIP;
        OP_WAKE: byte_out = CMD_WAKE;
        default: byte_out = CMD_SLEEP;
      endcase
    end
  end

  logic [15:0] qwait;
  assign qwait = (quarter_bit_ticks != 8'd0) ? {8'd0, quarter_bit_ticks - 8'd1} : 16'd0;

  logic busy;
  assign busy = phase_state != PH_IDLE;

  logic [2:0]  bit_inc;
  logic [16:0] byte_inc;
  assign bit_inc  = bit_counter + 3'd1;
  assign byte_inc = byte_counter + 17'd1;

  // page read address follows the byte index that holds after this edge
  logic [PW-1:0] pidx;
  always_comb begin
    pidx = byte_counter[PW-1:0] - PW'(4);
    if (accept && op == OP_TICK && busy && wait_counter == 16'd0 &&
        phase_state == PH_B3 && bit_inc == 3'd0)
      pidx = byte_inc[PW-1:0] - PW'(4);
  end

  // page buffer: registered read, single write port for data items
  always_ff @(posedge clk) begin
    page_rd <= page_buffer[pidx];
    if (accept && op == OP_DATA && phase_state == PH_IDLE &&
        page_fill < (PW+1)'(PAGE_BYTES))
      page_buffer[page_fill[PW-1:0]] <= in_data;
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_bit_ticks <= 8'd1;
      cs_settle_ticks   <= 16'd10;
      phase_state <= PH_IDLE;
      wait_counter <= '0; bit_counter <= '0; transmit_shift <= '0;
      receive_shift <= '0; byte_counter <= '0; command_address <= '0;
      active_command <= OP_TICK; page_fill <= '0; status_busy_seen <= 1'b0;
      segment <= SEG_A; read_length <= '0;
      pin_sck <= 1'b0; pin_mosi <= 1'b1; pin_csn <= 1'b1;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_QUARTER) quarter_bit_ticks <= cfg_data[7:0];
        else                          cs_settle_ticks   <= cfg_data;
      end
      if (accept) begin
        logic       rv, rl, dn, sck_n, mosi_n, csn_n;
        logic [7:0] rb;
        error_t     er;
        phase_t     ph_n;
        rv = 1'b0; rl = 1'b0; dn = 1'b0; rb = 8'd0; er = ERR_NONE;
        sck_n = pin_sck; mosi_n = pin_mosi; csn_n = pin_csn;
        ph_n = phase_state;
        if (op == OP_DATA) begin
          if (busy) er = ERR_BUSY;
          else if (page_fill < (PW+1)'(PAGE_BYTES)) page_fill <= page_fill + 1'b1;
        end else if (op != OP_TICK) begin
          if (busy) er = ERR_BUSY;
          else if ((op == OP_PROG || op == OP_SECT) && in_addr[PW-1:0] != '0)
            er = ERR_ALIGN;
          else if (op == OP_PROG && page_fill != (PW+1)'(PAGE_BYTES))
            er = ERR_PARTIAL;
          else begin
            if (op == OP_PROG) page_fill <= '0;
            active_command <= op; command_address <= in_addr;
            read_length <= in_len; segment <= SEG_A;
            status_busy_seen <= 1'b0; wait_counter <= '0;
            ph_n = PH_CS_ON;
          end
        end else if (busy) begin
          if (wait_counter != 16'd0) wait_counter <= wait_counter - 16'd1;
          else begin
            unique case (phase_state)
              PH_CS_ON: begin
                csn_n = 1'b0; bit_counter <= '0; byte_counter <= '0;
                wait_counter <= cs_settle_ticks;
                ph_n = PH_B0;
              end
              PH_B0: begin
                if (bit_counter == 3'd0) begin
                  transmit_shift <= byte_out; mosi_n = byte_out[7];
                end else mosi_n = transmit_shift[7];
                wait_counter <= qwait; ph_n = PH_B1;
              end
              PH_B1: begin
                sck_n = 1'b1; transmit_shift <= {transmit_shift[6:0], 1'b0};
                wait_counter <= qwait; ph_n = PH_B2;
              end
              PH_B2: begin
                receive_shift <= {receive_shift[6:0], in_miso};
                wait_counter <= qwait; ph_n = PH_B3;
              end
              PH_B3: begin
                sck_n = 1'b0; wait_counter <= qwait; bit_counter <= bit_inc;
                ph_n = PH_B0;
                if (bit_inc == 3'd0) begin
                  if (segment == SEG_POLL) begin
                    if (byte_counter == 17'd1) status_busy_seen <= receive_shift[0];
                  end else if (active_command == OP_READ && byte_counter >= 17'd4) begin
                    rv = 1'b1; rb = receive_shift; rl = (byte_inc == seg_len);
                  end
                  byte_counter <= byte_inc;
                  if (byte_inc >= seg_len) ph_n = PH_CS_OFF;
                end
              end
              PH_CS_OFF: begin
                csn_n = 1'b1; wait_counter <= cs_settle_ticks;
                if (segment == SEG_POLL) ph_n = status_busy_seen ? PH_CS_ON : PH_FINISH;
                else if (active_command == OP_READ) ph_n = PH_FINISH;
                else if (active_command == OP_PROG && segment == SEG_A) begin
                  segment <= SEG_B; ph_n = PH_CS_ON;
                end else begin
                  segment <= SEG_POLL; ph_n = PH_CS_ON;
                end
              end
              default: begin
                dn = 1'b1; ph_n = PH_IDLE;
              end
            endcase
          end
        end
        phase_state <= ph_n;
        pin_sck <= sck_n; pin_mosi <= mosi_n; pin_csn <= csn_n;
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {7'd0, er, dn, (ph_n != PH_IDLE), rl, rb, rv, csn_n, mosi_n, sck_n};
      end else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

`ifndef SYNTH
  // a done result never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[14] && m_axis_tdata[13]))
    else $error("done with busy");
  // read data only while chip select is low
  a_read_cs: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[3]) |-> !m_axis_tdata[2])
    else $error("read byte with cs high");
  // a result waiting and not taken holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
`endif
endmodule
